// ----- src/vqdrm_pkg.sv -----
// Shared types and constants of the virtqueue descriptor ring manager.
package vqdrm_pkg;

    localparam int RingSizeDefault = 256;

    localparam logic [1:0] StOk      = 2'd0;
    localparam logic [1:0] StFull    = 2'd1;
    localparam logic [1:0] StDropped = 2'd2;
    localparam logic [1:0] StBadComp = 2'd3;

    typedef struct packed {
        logic        req_type;
        logic [63:0] buf_addr;
        logic [31:0] buf_len;
        logic        device_writes;
        logic        first_buffer;
        logic        last_buffer;
        logic [15:0] task_tag;
        logic        no_notify;
        logic [7:0]  used_id;
        logic [31:0] used_len;
    } t_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  desc_slot;
        logic [1:0]  desc_flag_bits;
        logic        published;
        logic [7:0]  head_slot;
        logic [7:0]  avail_slot;
        logic [15:0] avail_index;
        logic        kick;
        logic [15:0] done_tag;
        logic [31:0] done_bytes;
    } t_result;

endpackage

// ----- src/virtqueue_descriptor_ring_manager_top.sv -----
// Top level of the virtqueue descriptor ring manager: intake queue and slot engine.
// A dropped buffer or bad completion is answered straight from idle; a post first scans past busy
// slots, then writes its descriptor; a completion frees its chain slot by slot, as does a rollback.
// Synchronous reset empties the queue and clears every slot busy bit; the receiver cannot stall.
module virtqueue_descriptor_ring_manager_top #(
    parameter int RING_SIZE = vqdrm_pkg::RingSizeDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_req_type,
    input  logic [63:0] i_buf_addr,
    input  logic [31:0] i_buf_len,
    input  logic        i_device_writes,
    input  logic        i_first_buffer,
    input  logic        i_last_buffer,
    input  logic [15:0] i_task_tag,
    input  logic        i_no_notify,
    input  logic [7:0]  i_used_id,
    input  logic [31:0] i_used_len,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [7:0]  o_desc_slot,
    output logic [1:0]  o_desc_flag_bits,
    output logic        o_published,
    output logic [7:0]  o_head_slot,
    output logic [7:0]  o_avail_slot,
    output logic [15:0] o_avail_index,
    output logic        o_kick,
    output logic [15:0] o_done_tag,
    output logic [31:0] o_done_bytes
);
    vqdrm_pkg::t_item   w_in, w_q;
    vqdrm_pkg::t_result w_res;
    logic w_full, w_qv, w_pop, w_idle;

    assign w_in = '{req_type: i_req_type, buf_addr: i_buf_addr, buf_len: i_buf_len,
                    device_writes: i_device_writes, first_buffer: i_first_buffer,
                    last_buffer: i_last_buffer, task_tag: i_task_tag,
                    no_notify: i_no_notify, used_id: i_used_id, used_len: i_used_len};
    assign busy = w_full;

    vqdrm_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(start && !w_full), .i_item(w_in),
        .i_pop(w_pop), .o_full(w_full), .o_valid(w_qv), .o_item(w_q)
    );

    vqdrm_back #(.RING_SIZE(RING_SIZE)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_qv), .i_item(w_q),
        .o_pop(w_pop), .o_idle(w_idle), .o_res_valid(o_valid), .o_res(w_res)
    );

    assign o_status = w_res.status;
    assign o_desc_slot = w_res.desc_slot;
    assign o_desc_flag_bits = w_res.desc_flag_bits;
    assign o_published = w_res.published;
    assign o_head_slot = w_res.head_slot;
    assign o_avail_slot = w_res.avail_slot;
    assign o_avail_index = w_res.avail_index;
    assign o_kick = w_res.kick;
    assign o_done_tag = w_res.done_tag;
    assign o_done_bytes = w_res.done_bytes;

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_idle && !w_qv) |=> !o_valid) else $error("result from idle back end");
    a_busy_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> w_qv) else $error("busy with empty queue");
    a_kick_pub: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kick) |-> o_published) else $error("kick without publish");
endmodule

// ----- src/vqdrm_front.sv -----
// Front end: accepts transactions into a two-entry queue toward the back end.
module vqdrm_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  vqdrm_pkg::t_item     i_item,
    input  logic                 i_pop,
    output logic                 o_full,
    output logic                 o_valid,
    output vqdrm_pkg::t_item     o_item
);
    vqdrm_pkg::t_item r_q [2];
    logic             r_wp, n_wp, r_rp, n_rp;
    logic [1:0]       r_cnt, n_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rp];

    always_comb begin
        n_wp  = r_wp ^ i_push;
        n_rp  = r_rp ^ i_pop;
        n_cnt = r_cnt + {1'b0, i_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp <= n_wp;
            r_rp <= n_rp;
            r_cnt <= n_cnt;
        end
        if (i_push) begin
            r_q[r_wp] <= i_item;
        end
    end

    a_no_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full)) else $error("queue overflow");
    a_no_under: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid)) else $error("queue underflow");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("count out of range");
endmodule

// ----- src/vqdrm_back.sv -----
// Back end: slot scan, descriptor writes, publishing and chain freeing.
module vqdrm_back #(
    parameter int RING_SIZE = vqdrm_pkg::RingSizeDefault
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  vqdrm_pkg::t_item     i_item,
    output logic                 o_pop,
    output logic                 o_idle,
    output logic                 o_res_valid,
    output vqdrm_pkg::t_result   o_res
);
    localparam int AW = $clog2(RING_SIZE);
    localparam logic [AW:0] LastStep = (AW+1)'(RING_SIZE - 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_COMP  = 7'b0000010,
        S_FREE  = 7'b0000100,
        S_ROLL  = 7'b0001000,
        S_SCAN  = 7'b0010000,
        S_WRITE = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state r_st, n_st;
    vqdrm_pkg::t_item   r_it, n_it;
    vqdrm_pkg::t_result r_res, n_res;
    logic               r_rv, n_rv;

    logic [RING_SIZE-1:0] r_busy, n_busy;
    logic [15:0] m_owner [RING_SIZE];
    logic [63:0] m_addr  [RING_SIZE];
    logic [31:0] m_len   [RING_SIZE];
    logic [1:0]  m_flag  [RING_SIZE];
    logic [AW-1:0] m_link [RING_SIZE];
    logic [AW-1:0] m_avail [RING_SIZE];

    logic [15:0]   r_rd_owner;
    logic [1:0]    r_rd_flag;
    logic [AW-1:0] r_rd_link;

    logic [15:0]   r_avail_cnt, n_avail_cnt, r_used_cnt, n_used_cnt;
    logic [AW-1:0] r_scan, n_scan, r_head, n_head, r_prev, n_prev, r_idx, n_idx;
    logic          r_failed, n_failed, r_open, n_open, r_roll_full, n_roll_full;
    logic          r_ph, n_ph;
    logic [AW:0]   r_n, n_n;
    logic [AW-1:0] w_idx;
    logic          w_bad_id;

    assign o_idle = (r_st == S_IDLE) && !r_rv;
    assign o_pop  = (r_st == S_IDLE) && i_valid;
    assign o_res_valid = r_rv;
    assign o_res = r_res;
    assign w_idx = AW'(i_item.used_id);
    assign w_bad_id = 32'(i_item.used_id) >= 32'(RING_SIZE);

    always_comb begin
        n_st = r_st;
        n_it = r_it;
        n_res = r_res;
        n_rv = 1'b0;
        n_busy = r_busy;
        n_avail_cnt = r_avail_cnt;
        n_used_cnt = r_used_cnt;
        n_scan = r_scan;
        n_head = r_head;
        n_prev = r_prev;
        n_idx = r_idx;
        n_failed = r_failed;
        n_open = r_open;
        n_roll_full = r_roll_full;
        n_ph = 1'b0;
        n_n = r_n;
        unique case (r_st)
            S_IDLE: begin
                if (i_valid) begin
                    n_it = i_item;
                    n_res = '0;
                    if (i_item.req_type) begin
                        n_res.desc_slot = i_item.used_id;
                        if (w_bad_id || !r_busy[w_idx]) begin
                            n_res.status = vqdrm_pkg::StBadComp;
                            n_rv = 1'b1;
                        end else begin
                            n_res.head_slot = i_item.used_id;
                            n_res.done_bytes = i_item.used_len;
                            n_idx = w_idx;
                            n_n = '0;
                            n_st = S_COMP;
                        end
                    end else if (i_item.first_buffer) begin
                        n_failed = 1'b0;
                        n_idx = r_open ? r_head : r_scan;
                        n_n = '0;
                        n_roll_full = 1'b0;
                        n_st = r_open ? S_ROLL : S_SCAN;
                    end else if (r_failed) begin
                        n_res.status = vqdrm_pkg::StDropped;
                        if (i_item.last_buffer) n_failed = 1'b0;
                        n_rv = 1'b1;
                    end else begin
                        n_idx = r_scan;
                        n_n = '0;
                        n_st = S_SCAN;
                    end
                end
            end
            S_COMP: begin
                if (r_ph) begin
                    n_busy[r_idx] = 1'b0;
                    if (r_n == '0) n_res.done_tag = r_rd_owner;
                    if (!r_rd_flag[0] || r_n == LastStep) begin
                        n_used_cnt = r_used_cnt + 16'd1;
                        n_rv = 1'b1;
                        n_st = S_IDLE;
                    end else begin
                        n_idx = r_rd_link;
                        n_n = r_n + (AW+1)'(1);
                    end
                end else begin
                    n_ph = 1'b1;
                end
            end
            S_ROLL: begin
                if (r_ph) begin
                    n_busy[r_idx] = 1'b0;
                    if (r_idx == r_prev || r_n == LastStep) begin
                        n_open = 1'b0;
                        if (r_roll_full) begin
                            n_rv = 1'b1;
                            n_st = S_IDLE;
                        end else begin
                            n_idx = r_scan;
                            n_n = '0;
                            n_st = S_SCAN;
                        end
                    end else begin
                        n_idx = r_rd_link;
                        n_n = r_n + (AW+1)'(1);
                    end
                end else begin
                    n_ph = 1'b1;
                end
            end
            S_SCAN: begin
                if (!r_busy[r_idx]) begin
                    n_st = S_WRITE;
                end else if (r_n == LastStep) begin
                    n_res.status = vqdrm_pkg::StFull;
                    n_res.head_slot = r_open ? 8'(r_head) : 8'd0;
                    n_failed = !r_it.last_buffer;
                    n_roll_full = 1'b1;
                    if (r_open) begin
                        n_idx = r_head;
                        n_n = '0;
                        n_st = S_ROLL;
                    end else begin
                        n_rv = 1'b1;
                        n_st = S_IDLE;
                    end
                end else begin
                    n_idx = r_idx + AW'(1);
                    n_n = r_n + (AW+1)'(1);
                end
            end
            S_WRITE: begin
                n_busy[r_idx] = 1'b1;
                n_scan = r_idx + AW'(1);
                n_prev = r_idx;
                n_res.desc_slot = 8'(r_idx);
                n_res.desc_flag_bits = {r_it.device_writes, !r_it.last_buffer};
                n_res.head_slot = r_open ? 8'(r_head) : 8'(r_idx);
                if (!r_open) n_head = r_idx;
                n_open = !r_it.last_buffer;
                if (r_it.last_buffer) begin
                    n_avail_cnt = r_avail_cnt + 16'd1;
                    n_res.published = 1'b1;
                    n_res.avail_slot = 8'(r_avail_cnt[AW-1:0]);
                    n_res.avail_index = r_avail_cnt + 16'd1;
                    n_res.kick = !r_it.no_notify;
                end
                n_st = S_OUT;
            end
            S_OUT: begin
                n_rv = 1'b1;
                n_st = S_IDLE;
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_rv <= 1'b0;
            r_busy <= '0;
            r_avail_cnt <= '0;
            r_used_cnt <= '0;
            r_scan <= '0;
            r_head <= '0;
            r_prev <= '0;
            r_idx <= '0;
            r_failed <= 1'b0;
            r_open <= 1'b0;
            r_roll_full <= 1'b0;
            r_ph <= 1'b0;
            r_n <= '0;
        end else begin
            r_st <= n_st;
            r_rv <= n_rv;
            r_busy <= n_busy;
            r_avail_cnt <= n_avail_cnt;
            r_used_cnt <= n_used_cnt;
            r_scan <= n_scan;
            r_head <= n_head;
            r_prev <= n_prev;
            r_idx <= n_idx;
            r_failed <= n_failed;
            r_open <= n_open;
            r_roll_full <= n_roll_full;
            r_ph <= n_ph;
            r_n <= n_n;
        end
        r_it <= n_it;
        r_res <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (r_st == S_WRITE) begin
            m_owner[r_idx] <= r_it.task_tag;
            m_addr[r_idx]  <= r_it.buf_addr;
            m_len[r_idx]   <= r_it.buf_len;
            m_flag[r_idx]  <= {r_it.device_writes, !r_it.last_buffer};
            if (r_open) m_link[r_prev] <= r_idx;
            if (r_it.last_buffer) m_avail[r_avail_cnt[AW-1:0]] <= r_open ? r_head : r_idx;
        end
        r_rd_owner <= m_owner[r_idx];
        r_rd_flag  <= m_flag[r_idx];
        r_rd_link  <= m_link[r_idx];
    end

    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_st)) else $error("state not one-hot");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> !o_res_valid || $past(r_st == S_IDLE)) else $error("pop while busy");
    a_write_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_WRITE) |=> ##1 o_res_valid) else $error("missing result");
endmodule
